>>> hdl/rzph_pkg.sv
`timescale 1ns / 1ps

package rzph_pkg;

  localparam int MAX_BANDS  = 16;
  localparam int COORD_BITS = 11;
  localparam int COUNT_BITS = 22;

  localparam int BAND_IDX_BITS = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
  localparam int BAND_CNT_BITS = 5;
  localparam int HOVER_BITS    = 5;
  localparam int BAL_BITS      = 24;
  localparam int PIX_BITS      = 8;
  localparam int LIM_BITS      = COORD_BITS + BAND_IDX_BITS + 1;

  localparam int APB_ADDR_BITS = 4;
  localparam int APB_DATA_BITS = 32;

  localparam logic [1:0] REG_BAND_COUNT  = 2'd0;
  localparam logic [1:0] REG_BAND_WIDTH  = 2'd1;
  localparam logic [1:0] REG_BOTTOM_ROW  = 2'd2;

  localparam logic [BAND_CNT_BITS-1:0] RST_BAND_COUNT = 5'd4;
  localparam logic [COORD_BITS-1:0]    RST_BAND_WIDTH = COORD_BITS'(320);
  localparam logic [COORD_BITS-1:0]    RST_BOTTOM_ROW = COORD_BITS'(540);

  localparam logic [PIX_BITS-1:0] LOW_HUE_MAX  = 8'd5;
  localparam logic [PIX_BITS-1:0] LOW_SV_MIN   = 8'd140;
  localparam logic [PIX_BITS-1:0] HIGH_HUE_MIN = 8'd160;
  localparam logic [PIX_BITS-1:0] HIGH_HUE_MAX = 8'd180;
  localparam logic [PIX_BITS-1:0] HIGH_SV_MIN  = 8'd120;

  typedef struct packed {
    logic [BAND_CNT_BITS-1:0] band_count;
    logic [COORD_BITS-1:0]    band_width;
    logic [COORD_BITS-1:0]    bottom_start_row;
  } cfg_t;

  typedef struct packed {
    logic                     hold;
    logic                     scan_init;
    logic                     scan_step;
    logic                     finish;
    logic [BAND_IDX_BITS-1:0] idx;
  } ctrl_cmd_t;

  typedef struct packed {
    logic frame_done;
    logic scan_last;
    logic out_free;
  } dp_status_t;

endpackage

>>> hdl/rzph_band_locate.sv
`timescale 1ns / 1ps

module rzph_band_locate (
  input  logic [rzph_pkg::COORD_BITS-1:0]    column,
  input  logic [rzph_pkg::COORD_BITS-1:0]    band_width,
  input  logic [rzph_pkg::BAND_IDX_BITS-1:0] last_band,
  output logic [rzph_pkg::MAX_BANDS-1:0]     band_sel
);
  import rzph_pkg::*;

  logic [MAX_BANDS-1:0] hit;
  logic [LIM_BITS-1:0]  col_ext;
  logic [LIM_BITS-1:0]  width_ext;

  assign col_ext   = LIM_BITS'(column);
  assign width_ext = LIM_BITS'(band_width);

  for (genvar i = 0; i < MAX_BANDS; i++) begin : g_band
    localparam logic [LIM_BITS-1:0] LO_MUL = LIM_BITS'(i);
    localparam logic [LIM_BITS-1:0] HI_MUL = LIM_BITS'(i + 1);
    localparam logic [BAND_IDX_BITS-1:0] IDX = BAND_IDX_BITS'(i);
    logic [LIM_BITS-1:0] lo;
    logic [LIM_BITS-1:0] hi;
    assign lo = width_ext * LO_MUL;
    assign hi = width_ext * HI_MUL;
    assign hit[i] = (col_ext >= lo) && (col_ext <= hi) && (IDX <= last_band);
  end

  // lowest matching band, band 0 when nothing matches
  assign band_sel = (hit == '0) ? MAX_BANDS'(1) : (hit & (~hit + MAX_BANDS'(1)));

endmodule

>>> hdl/rzph_cfg_regs.sv
`timescale 1ns / 1ps

module rzph_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rzph_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [rzph_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [rzph_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                              pready,
  output rzph_pkg::cfg_t                    cfg
);
  import rzph_pkg::*;

  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.band_count       <= RST_BAND_COUNT;
      cfg.band_width       <= RST_BAND_WIDTH;
      cfg.bottom_start_row <= RST_BOTTOM_ROW;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_BAND_COUNT: cfg.band_count       <= pwdata[BAND_CNT_BITS-1:0];
        REG_BAND_WIDTH: cfg.band_width       <= pwdata[COORD_BITS-1:0];
        REG_BOTTOM_ROW: cfg.bottom_start_row <= pwdata[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BAND_COUNT: prdata = APB_DATA_BITS'(cfg.band_count);
      REG_BAND_WIDTH: prdata = APB_DATA_BITS'(cfg.band_width);
      REG_BOTTOM_ROW: prdata = APB_DATA_BITS'(cfg.bottom_start_row);
      default:        prdata = '0;
    endcase
  end

endmodule

>>> hdl/rzph_datapath.sv
`timescale 1ns / 1ps

module rzph_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  rzph_pkg::cfg_t                   cfg,
  input  rzph_pkg::ctrl_cmd_t              cmd,
  output rzph_pkg::dp_status_t             status,
  input  logic                             pixel_valid,
  input  logic [rzph_pkg::PIX_BITS-1:0]    hue,
  input  logic [rzph_pkg::PIX_BITS-1:0]    saturation,
  input  logic [rzph_pkg::PIX_BITS-1:0]    brightness,
  input  logic [rzph_pkg::COORD_BITS-1:0]  column,
  input  logic [rzph_pkg::COORD_BITS-1:0]  row,
  input  logic                             frame_end,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [rzph_pkg::HOVER_BITS-1:0]  hovered_band,
  output logic                             upper_majority
);
  import rzph_pkg::*;

  localparam logic signed [BAL_BITS-1:0] BAL_MAX = {1'b0, {(BAL_BITS-1){1'b1}}};
  localparam logic signed [BAL_BITS-1:0] BAL_MIN = {1'b1, {(BAL_BITS-1){1'b0}}};

  logic [BAND_IDX_BITS-1:0] last_band;
  logic [MAX_BANDS-1:0]     band_sel;
  logic                     accept;
  logic                     red;

  logic                     s1_valid;
  logic                     s1_red;
  logic                     s1_last;
  logic                     s1_lower;
  logic [MAX_BANDS-1:0]     s1_band;

  logic [COUNT_BITS-1:0]    counts [MAX_BANDS];
  logic signed [BAL_BITS-1:0] balance;
  logic [BAND_IDX_BITS-1:0] best_idx;
  logic [COUNT_BITS-1:0]    best_val;
  logic [COUNT_BITS-1:0]    scan_val;

  always_comb begin
    if (cfg.band_count == '0) begin
      last_band = '0;
    end else if (32'(cfg.band_count) > MAX_BANDS) begin
      last_band = BAND_IDX_BITS'(MAX_BANDS - 1);
    end else begin
      last_band = BAND_IDX_BITS'(cfg.band_count - 1'b1);
    end
  end

  rzph_band_locate u_locate (
    .column     (column),
    .band_width (cfg.band_width),
    .last_band  (last_band),
    .band_sel   (band_sel)
  );

  assign red = ((hue <= LOW_HUE_MAX) && (saturation >= LOW_SV_MIN) &&
                (brightness >= LOW_SV_MIN)) ||
               ((hue >= HIGH_HUE_MIN) && (hue <= HIGH_HUE_MAX) &&
                (saturation >= HIGH_SV_MIN) && (brightness >= HIGH_SV_MIN));

  assign accept = pixel_valid && !cmd.hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_red   <= red;
      s1_last  <= frame_end;
      s1_lower <= row >= cfg.bottom_start_row;
      s1_band  <= band_sel;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_BANDS; i++) begin
      if (rst || cmd.finish) begin
        counts[i] <= '0;
      end else if (s1_valid && s1_red && s1_band[i] && (counts[i] != '1)) begin
        counts[i] <= counts[i] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      balance <= '0;
    end else if (s1_valid && s1_red) begin
      if (s1_lower) begin
        if (balance != BAL_MIN) balance <= balance - 1'b1;
      end else begin
        if (balance != BAL_MAX) balance <= balance + 1'b1;
      end
    end
  end

  assign scan_val = counts[cmd.idx];

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      best_idx <= '0;
      best_val <= '0;
    end else if (cmd.scan_step && (scan_val > best_val)) begin
      best_idx <= cmd.idx;
      best_val <= scan_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.finish) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      hovered_band   <= HOVER_BITS'({1'b0, best_idx} + 1'b1);
      upper_majority <= balance > 0;
    end
  end

  assign status.frame_done = s1_valid && s1_last;
  assign status.scan_last  = cmd.idx == last_band;
  assign status.out_free   = !result_valid || !result_stall;

endmodule

>>> hdl/rzph_ctrl.sv
`timescale 1ns / 1ps

module rzph_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  rzph_pkg::dp_status_t status,
  output rzph_pkg::ctrl_cmd_t  cmd
);
  import rzph_pkg::*;

  localparam logic [1:0] ST_RUN    = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]               state;
  logic [1:0]               state_next;
  logic [BAND_IDX_BITS-1:0] idx;
  logic [BAND_IDX_BITS-1:0] idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  always_comb begin
    state_next    = state;
    idx_next      = idx;
    cmd.hold      = 1'b1;
    cmd.scan_init = 1'b0;
    cmd.scan_step = 1'b0;
    cmd.finish    = 1'b0;
    cmd.idx       = idx;
    unique case (state)
      ST_RUN: begin
        // last pixel of the frame is being counted this cycle
        cmd.hold = status.frame_done;
        if (status.frame_done) begin
          cmd.scan_init = 1'b1;
          idx_next      = '0;
          state_next    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          state_next = ST_FINISH;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_RUN;
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

endmodule

>>> hdl/red_zone_pixel_histogram.sv
`timescale 1ns / 1ps

// Channel   Handshake                    Payload
// pixel     pixel_valid / pixel_stall    hue, saturation, brightness, column, row, frame_end
// result    result_valid / result_stall  hovered_band, upper_majority
// config    APB write/read               band_count @0x0, band_width @0x4, bottom_start_row @0x8
//
// One pixel transfer per cycle while the frame runs; each pixel is classified in
// a register stage, and a red pixel is counted into its band counter on the next cycle.
// After the frame_end pixel, input stalls while that pixel is counted, the band counters
// in use are scanned one per cycle, and the result is loaded; the result register waits
// until no result is pending (result_valid or result_stall low), and input stays stalled until then.
// Synchronous reset clears counters, balance and control and loads config reset values.

module red_zone_pixel_histogram (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rzph_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [rzph_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [rzph_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                              pready,
  input  logic                              pixel_valid,
  output logic                              pixel_stall,
  input  logic [rzph_pkg::PIX_BITS-1:0]     hue,
  input  logic [rzph_pkg::PIX_BITS-1:0]     saturation,
  input  logic [rzph_pkg::PIX_BITS-1:0]     brightness,
  input  logic [rzph_pkg::COORD_BITS-1:0]   column,
  input  logic [rzph_pkg::COORD_BITS-1:0]   row,
  input  logic                              frame_end,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [rzph_pkg::HOVER_BITS-1:0]   hovered_band,
  output logic                              upper_majority
);
  import rzph_pkg::*;

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  rzph_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rzph_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  rzph_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .cmd            (cmd),
    .status         (status),
    .pixel_valid    (pixel_valid),
    .hue            (hue),
    .saturation     (saturation),
    .brightness     (brightness),
    .column         (column),
    .row            (row),
    .frame_end      (frame_end),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .hovered_band   (hovered_band),
    .upper_majority (upper_majority)
  );

  assign pixel_stall = rst || cmd.hold;

  a_stall_after_last: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && !pixel_stall && frame_end) |=> pixel_stall)
    else $error("pixel accepted right after frame end");

  a_result_after_scan: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(pixel_stall))
    else $error("result appeared without an end-of-frame scan");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.scan_init, cmd.scan_step, cmd.finish}))
    else $error("conflicting controller commands");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!result_valid || !result_stall))
    else $error("pending result overwritten");

endmodule

>>> bench/red_zone_pixel_histogram_tb.sv
`timescale 1ns / 1ps

module red_zone_pixel_histogram_tb;
  import rzph_pkg::*;

  localparam int QUIET_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 24;
  localparam logic signed [BAL_BITS-1:0] BAL_FLOOR = {1'b1, {(BAL_BITS-1){1'b0}}};
  localparam logic signed [BAL_BITS-1:0] BAL_CEIL  = {1'b0, {(BAL_BITS-1){1'b1}}};

  typedef struct packed {
    logic [PIX_BITS-1:0]   hue;
    logic [PIX_BITS-1:0]   saturation;
    logic [PIX_BITS-1:0]   brightness;
    logic [COORD_BITS-1:0] column;
    logic [COORD_BITS-1:0] row;
    logic                  frame_end;
  } pixel_t;

  typedef struct packed {
    logic [HOVER_BITS-1:0] hovered_band;
    logic                  upper_majority;
  } zone_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr = '0;
  logic [APB_DATA_BITS-1:0] pwdata = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic pready;
  logic pixel_valid = 1'b0;
  logic pixel_stall;
  logic [PIX_BITS-1:0] hue = '0;
  logic [PIX_BITS-1:0] saturation = '0;
  logic [PIX_BITS-1:0] brightness = '0;
  logic [COORD_BITS-1:0] column = '0;
  logic [COORD_BITS-1:0] row = '0;
  logic frame_end = 1'b0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [HOVER_BITS-1:0] hovered_band;
  logic upper_majority;

  red_zone_pixel_histogram dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .hue(hue),
    .saturation(saturation),
    .brightness(brightness),
    .column(column),
    .row(row),
    .frame_end(frame_end),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .hovered_band(hovered_band),
    .upper_majority(upper_majority)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic [BAND_CNT_BITS-1:0] cfg_band_count = RST_BAND_COUNT;
  logic [COORD_BITS-1:0]    cfg_band_width = RST_BAND_WIDTH;
  logic [COORD_BITS-1:0]    cfg_bottom_row = RST_BOTTOM_ROW;
  logic [COUNT_BITS-1:0]    band_tally [MAX_BANDS] = '{default: '0};
  logic signed [BAL_BITS-1:0] red_balance = '0;

  zone_t zone_queue[$];
  zone_t zone_want;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_left = 0;
  bit pace_on = 1'b0;

  function automatic int unsigned active_bands();
    if (cfg_band_count == 0) return 1;
    if (32'(cfg_band_count) > MAX_BANDS) return MAX_BANDS;
    return 32'(cfg_band_count);
  endfunction

  function automatic void tally_pixel(input pixel_t p);
    int unsigned n, b, best, i;
    bit red, found;
    zone_t z;
    n = active_bands();
    red = (p.hue <= LOW_HUE_MAX && p.saturation >= LOW_SV_MIN && p.brightness >= LOW_SV_MIN) ||
          (p.hue >= HIGH_HUE_MIN && p.hue <= HIGH_HUE_MAX &&
           p.saturation >= HIGH_SV_MIN && p.brightness >= HIGH_SV_MIN);
    if (red) begin
      b = 0;
      found = 1'b0;
      for (i = 0; i < n; i++) begin
        if (!found && p.column >= cfg_band_width * i && p.column <= cfg_band_width * (i + 1)) begin
          b = i;
          found = 1'b1;
        end
      end
      if (band_tally[b] != {COUNT_BITS{1'b1}}) band_tally[b]++;
      if (p.row >= cfg_bottom_row) begin
        if (red_balance != BAL_FLOOR) red_balance--;
      end else begin
        if (red_balance != BAL_CEIL) red_balance++;
      end
    end
    if (p.frame_end) begin
      best = 0;
      for (i = 1; i < n; i++) begin
        if (band_tally[i] > band_tally[best]) best = i;
      end
      z.hovered_band = HOVER_BITS'(best + 1);
      z.upper_majority = (red_balance > 0);
      zone_queue = {zone_queue, z};
      foreach (band_tally[j]) band_tally[j] = '0;
      red_balance = '0;
    end
  endfunction

  function automatic void flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  function automatic pixel_t pix(input int h, input int s, input int v, input int x, input int y,
                                 input bit last);
    pixel_t p;
    p.hue = PIX_BITS'(h);
    p.saturation = PIX_BITS'(s);
    p.brightness = PIX_BITS'(v);
    p.column = COORD_BITS'(x);
    p.row = COORD_BITS'(y);
    p.frame_end = last;
    return p;
  endfunction

  task automatic push_pixel(input pixel_t p);
    int unsigned gap;
    gap = pace_on ? $urandom_range(0, 12) : 0;
    if (gap != 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_valid <= 1'b1;
    hue <= p.hue;
    saturation <= p.saturation;
    brightness <= p.brightness;
    column <= p.column;
    row <= p.row;
    frame_end <= p.frame_end;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    tally_pixel(p);
  endtask

  task automatic settle();
    pixel_valid <= 1'b0;
    while (zone_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [APB_DATA_BITS-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_BITS'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_BAND_COUNT: cfg_band_count = value[BAND_CNT_BITS-1:0];
      REG_BAND_WIDTH: cfg_band_width = value[COORD_BITS-1:0];
      REG_BOTTOM_ROW: cfg_bottom_row = value[COORD_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic set_zones(input int bc, input int bw, input int bsr);
    write_reg(REG_BAND_COUNT, bc);
    write_reg(REG_BAND_WIDTH, bw);
    write_reg(REG_BOTTOM_ROW, bsr);
  endtask

  // reset config: 4 bands of 320, bottom rows from 540
  task automatic test_red_classes();
    pace_on = 1'b0;
    push_pixel(pix(0, 140, 140, 0, 0, 0));
    push_pixel(pix(5, 255, 255, 320, 539, 0));
    push_pixel(pix(6, 255, 255, 700, 0, 0));
    push_pixel(pix(5, 139, 255, 700, 0, 0));
    push_pixel(pix(159, 255, 255, 700, 0, 0));
    push_pixel(pix(160, 120, 120, 640, 540, 0));
    push_pixel(pix(180, 255, 119, 700, 0, 0));
    push_pixel(pix(181, 255, 255, 700, 0, 0));
    push_pixel(pix(255, 255, 255, 2047, 2047, 1));
  endtask

  task automatic test_band_edges();
    pace_on = 1'b1;
    push_pixel(pix(170, 200, 200, 641, 2047, 0));
    push_pixel(pix(0, 255, 255, 1280, 100, 0));
    push_pixel(pix(0, 255, 255, 1281, 100, 0));
    push_pixel(pix(0, 255, 255, 960, 540, 0));
    // frame end pixel counts first and makes a tie between bands 2 and 3
    push_pixel(pix(0, 255, 255, 1100, 0, 1));
    push_pixel(pix(90, 10, 10, 0, 0, 1));
    push_pixel(pix(3, 200, 200, 1279, 2047, 1));
  endtask

  task automatic test_config_extremes();
    settle();
    set_zones(0, 0, 0);
    push_pixel(pix(0, 255, 255, 0, 0, 0));
    push_pixel(pix(175, 255, 255, 5, 2047, 0));
    push_pixel(pix(2, 150, 150, 1, 3, 1));
    settle();
    set_zones(31, 2047, 2047);
    push_pixel(pix(1, 255, 255, 2047, 2046, 1));
    settle();
    set_zones(16, 1, 1024);
    push_pixel(pix(0, 255, 255, 2047, 0, 0));
    push_pixel(pix(165, 255, 255, 16, 1024, 0));
    push_pixel(pix(4, 200, 200, 16, 1023, 1));
  endtask

  function automatic pixel_t random_pixel(input int unsigned favored);
    pixel_t p;
    int unsigned kind, x;
    int y;
    kind = $urandom_range(0, 9);
    p.hue = PIX_BITS'($urandom_range(0, 255));
    p.saturation = PIX_BITS'($urandom_range(0, 255));
    p.brightness = PIX_BITS'($urandom_range(0, 255));
    if (kind <= 3) begin
      p.hue = PIX_BITS'($urandom_range(0, LOW_HUE_MAX));
      p.saturation = PIX_BITS'($urandom_range(LOW_SV_MIN, 255));
      p.brightness = PIX_BITS'($urandom_range(LOW_SV_MIN, 255));
    end else if (kind <= 6) begin
      p.hue = PIX_BITS'($urandom_range(HIGH_HUE_MIN, HIGH_HUE_MAX));
      p.saturation = PIX_BITS'($urandom_range(HIGH_SV_MIN, 255));
      p.brightness = PIX_BITS'($urandom_range(HIGH_SV_MIN, 255));
    end else if (kind == 7) begin
      p.saturation = PIX_BITS'($urandom_range(LOW_SV_MIN, 255));
      p.brightness = PIX_BITS'($urandom_range(LOW_SV_MIN, 255));
      case ($urandom_range(0, 3))
        0: p.hue = PIX_BITS'($urandom_range(LOW_HUE_MAX + 1, HIGH_HUE_MIN - 1));
        1: p.hue = PIX_BITS'($urandom_range(HIGH_HUE_MAX + 1, 255));
        2: begin
          p.hue = PIX_BITS'($urandom_range(0, LOW_HUE_MAX));
          p.saturation = PIX_BITS'(LOW_SV_MIN - 1);
        end
        default: begin
          p.hue = PIX_BITS'($urandom_range(HIGH_HUE_MIN, HIGH_HUE_MAX));
          p.brightness = PIX_BITS'(HIGH_SV_MIN - 1);
        end
      endcase
    end
    case ($urandom_range(0, 3))
      0, 1: x = cfg_band_width * favored + $urandom_range(0, cfg_band_width);
      2: x = cfg_band_width * $urandom_range(0, MAX_BANDS);
      default: x = $urandom_range(0, 2047);
    endcase
    if (x > 2047) x = $urandom_range(0, 2047);
    p.column = COORD_BITS'(x);
    if ($urandom_range(0, 3) == 0) begin
      y = int'(cfg_bottom_row) + int'($urandom_range(0, 2)) - 1;
      if (y < 0) y = 0;
      if (y > 2047) y = 2047;
    end else begin
      y = $urandom_range(0, 2047);
    end
    p.row = COORD_BITS'(y);
    p.frame_end = 1'b0;
    return p;
  endfunction

  task automatic pick_config();
    int unsigned bc, bw, bsr, n;
    case ($urandom_range(0, 7))
      0: bc = 0;
      1: bc = $urandom_range(MAX_BANDS + 1, 31);
      2: bc = MAX_BANDS;
      3: bc = 1;
      default: bc = $urandom_range(1, MAX_BANDS);
    endcase
    n = (bc == 0) ? 1 : (bc > MAX_BANDS) ? MAX_BANDS : bc;
    case ($urandom_range(0, 7))
      0: bw = 0;
      1: bw = 2047;
      2: bw = 1;
      default: bw = $urandom_range(1, 2047 / n);
    endcase
    case ($urandom_range(0, 5))
      0: bsr = 0;
      1: bsr = 2047;
      default: bsr = $urandom_range(0, 2047);
    endcase
    // upper bus bits are junk half the time
    if ($urandom_range(0, 1)) begin
      bc = bc | ($urandom << BAND_CNT_BITS);
      bw = bw | ($urandom << COORD_BITS);
      bsr = bsr | ($urandom << COORD_BITS);
    end
    set_zones(bc, bw, bsr);
  endtask

  task automatic test_random_frames();
    int unsigned sent, frames, len, favored, k;
    pixel_t p;
    sent = 0;
    while (sent < 1800) begin
      settle();
      pick_config();
      frames = $urandom_range(3, 8);
      while (frames != 0) begin
        pace_on = ($urandom_range(0, 3) != 0);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
        favored = $urandom_range(0, active_bands() - 1);
        for (k = 1; k <= len; k++) begin
          p = random_pixel(favored);
          p.frame_end = (k == len);
          push_pixel(p);
        end
        sent += len;
        frames--;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (zone_queue.size() == 0) begin
        flag_error($sformatf("result with none pending: band %0d upper %0b",
                             hovered_band, upper_majority));
      end else begin
        zone_want = zone_queue.pop_front();
        if (hovered_band !== zone_want.hovered_band)
          flag_error($sformatf("hovered_band exp %0d got %0d",
                               zone_want.hovered_band, hovered_band));
        if (upper_majority !== zone_want.upper_majority)
          flag_error($sformatf("upper_majority exp %0b got %0b",
                               zone_want.upper_majority, upper_majority));
      end
      hold_left = pace_on ? $urandom_range(0, 12) : 0;
    end else if (hold_left != 0) begin
      hold_left--;
    end
    result_stall <= (hold_left != 0);
  end

  always @(posedge clk) begin
    if (rst || (pixel_valid && !pixel_stall) || (result_valid && !result_stall) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_red_classes();
    test_band_edges();
    test_config_extremes();
    test_random_frames();
    settle();
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
